// ----- rtl/core/tlbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, outcome codes and control structs of the tlb / page table
// translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // address geometry
    localparam int OFFSET_BITS = 10;
    localparam int NUM_PAGES   = 64;
    localparam int NUM_FRAMES  = 16;
    localparam int TLB_ENTRIES = 8;

    // fixed field widths of the stream beats
    localparam int VA_W     = 16;
    localparam int VICTIM_W = 6;
    localparam int PA_W     = 14;
    localparam int OUTC_W   = 2;
    localparam int EVICT_W  = 6;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // derived internal widths
    localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int SLOT_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    // translation outcome codes
    typedef enum logic [OUTC_W-1:0] {
        OUT_TLB_HIT   = 2'd0,
        OUT_PT_HIT    = 2'd1,
        OUT_FAULT     = 2'd2,
        OUT_EVICT     = 2'd3
    } t_outcome;

    // tlb lookup result
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_look;

    // tlb refill and invalidation request
    typedef struct packed {
        logic               fill_en;
        logic [PAGE_W-1:0]  fill_page;
        logic [FRAME_W-1:0] fill_frame;
        logic               drop_en;
        logic [PAGE_W-1:0]  drop_page;
    } t_tlb_upd;

    // lowest free frame
    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
    } t_free;

    // page table write back request
    typedef struct packed {
        logic               map_en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               evict_en;
        logic [PAGE_W-1:0]  victim;
    } t_pt_upd;

endpackage

// ----- rtl/core/tlbpt_tlb.sv -----
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative tlb: parallel tag compare with lowest-entry priority,
// round-robin refill and invalidation of every entry tagged with a page.
// ----------------------------------------------------------------------------
module tlbpt_tlb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0] i_look_page,
    output tlbpt_pkg::t_tlb_look         o_look,
    input  tlbpt_pkg::t_tlb_upd          i_upd
);
    import tlbpt_pkg::*;

    logic [PAGE_W-1:0]  r_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0] r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [SLOT_W-1:0]  r_next_slot;
    logic [SLOT_W-1:0]  n_next_slot;

    // first valid matching entry wins
    always_comb begin
        o_look = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_look_page)) begin
                o_look.hit   = 1'b1;
                o_look.frame = r_frame[i];
            end
        end
    end

    // round-robin slot pointer
    always_comb begin
        if (r_next_slot == SLOT_W'(TLB_ENTRIES - 1)) begin
            n_next_slot = '0;
        end else begin
            n_next_slot = r_next_slot + SLOT_W'(1);
        end
    end

    // valid bits and pointer: drop first, the refill of the same beat wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next_slot <= '0;
        end else begin
            if (i_upd.drop_en) begin
                for (int i = 0; i < TLB_ENTRIES; i++) begin
                    if (r_tag[i] == i_upd.drop_page) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
            if (i_upd.fill_en) begin
                r_valid[r_next_slot] <= 1'b1;
                r_next_slot          <= n_next_slot;
            end
        end
    end

    // tag and frame payload
    always_ff @(posedge i_clk) begin
        if (i_upd.fill_en) begin
            r_tag[r_next_slot]   <= i_upd.fill_page;
            r_frame[r_next_slot] <= i_upd.fill_frame;
        end
    end

endmodule

// ----- rtl/core/tlbpt_pt.sv -----
// ----------------------------------------------------------------------------
// tlbpt_pt
// Page table: frame memory with registered read, present and written bits
// per page, frame usage bits and the lowest free frame search.
// ----------------------------------------------------------------------------
module tlbpt_pt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  i_look_page,
    output logic                          o_look_present,
    input  logic                          i_rd_en,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  i_rd_addr,
    output logic [tlbpt_pkg::FRAME_W-1:0] o_rd_frame,
    output tlbpt_pkg::t_free              o_free,
    input  tlbpt_pkg::t_pt_upd            i_upd
);
    import tlbpt_pkg::*;

    // the referenced bit has no effect on any translation and is not kept
    logic [FRAME_W-1:0]    r_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0]  r_present;
    logic [NUM_PAGES-1:0]  r_written;
    logic [NUM_FRAMES-1:0] r_in_use;
    logic [FRAME_W-1:0]    r_rd_data;
    logic                  r_rd_written;

    assign o_look_present = r_present[i_look_page];

    // a never written entry reads as frame zero
    assign o_rd_frame = r_rd_written ? r_rd_data : '0;

    // frame memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_upd.map_en) begin
            r_mem[i_upd.page] <= i_upd.frame;
        end
        if (i_rd_en) begin
            r_rd_data    <= r_mem[i_rd_addr];
            r_rd_written <= r_written[i_rd_addr];
        end
    end

    // status bits: victim cleared before the faulting page is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_written <= '0;
            r_in_use  <= '0;
        end else begin
            if (i_upd.evict_en) begin
                r_present[i_upd.victim] <= 1'b0;
            end
            if (i_upd.map_en) begin
                r_present[i_upd.page] <= 1'b1;
                r_written[i_upd.page] <= 1'b1;
                r_in_use[i_upd.frame] <= 1'b1;
            end
        end
    end

    // lowest free frame
    always_comb begin
        o_free = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                o_free.found = 1'b1;
                o_free.frame = FRAME_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/tlb_page_table_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Demand paging translator: tlb, then page table, then fault into the
// lowest free frame or eviction of the page named with the request.
//
//   channel  dir  ports          beat contents
//   s        in   i_s_t*         virtual address, victim page
//   m        out  o_m_t*         physical address, outcome, evicted page
//
// In each translation the accept cycle issues the page table memory read,
// then the execute state resolves tlb, page table or fault on the read
// data and writes every store back.
// Reset clears the tlb valid, present, written and frame usage bits at once.
// A result waits in the output register; the next request is still taken,
// and its execute state holds until the output register is free.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // [15:0] vaddr, [21:16] victim_page
    input  logic [tlbpt_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [13:0] physical_address, [15:14] outcome, [21:16] evicted_page
    output logic [tlbpt_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready
);
    import tlbpt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [PAGE_W-1:0]      r_victim;
    logic                   r_present;
    logic                   r_out_valid;
    logic [PA_W-1:0]        r_out_pa;
    t_outcome               r_out_outcome;
    logic [EVICT_W-1:0]     r_out_evict;
    logic                   n_out_valid;

    logic                   s_accept;
    logic                   exec_go;
    logic [PAGE_W-1:0]      in_page;
    logic [PAGE_W-1:0]      in_victim;
    logic                   in_present;
    logic [FRAME_W-1:0]     rd_frame;
    t_tlb_look              tlb_look;
    t_tlb_upd               tlb_upd;
    t_free                  free;
    t_pt_upd                pt_upd;
    logic [FRAME_W-1:0]     res_frame;
    t_outcome               res_outcome;
    logic [EVICT_W-1:0]     res_evict;

    // request decode
    assign in_page   = PAGE_W'(i_s_tdata[VA_W-1:OFFSET_BITS] % NUM_PAGES);
    assign in_victim = PAGE_W'(i_s_tdata[VA_W+VICTIM_W-1:VA_W] % NUM_PAGES);

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign exec_go    = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);

    tlbpt_tlb u_tlb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_look_page (r_page),
        .o_look      (tlb_look),
        .i_upd       (tlb_upd)
    );

    // read the page's own frame when present, else the victim's
    tlbpt_pt u_pt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_look_page    (in_page),
        .o_look_present (in_present),
        .i_rd_en        (s_accept),
        .i_rd_addr      (in_present ? in_page : in_victim),
        .o_rd_frame     (rd_frame),
        .o_free         (free),
        .i_upd          (pt_upd)
    );

    // resolve the translation and build the write back
    always_comb begin
        res_frame   = '0;
        res_outcome = OUT_TLB_HIT;
        res_evict   = '0;
        tlb_upd     = '0;
        pt_upd      = '0;
        if (tlb_look.hit) begin
            res_frame   = tlb_look.frame;
            res_outcome = OUT_TLB_HIT;
        end else if (r_present) begin
            res_frame   = rd_frame;
            res_outcome = OUT_PT_HIT;
            tlb_upd.fill_en = exec_go;
        end else begin
            if (free.found) begin
                res_frame   = free.frame;
                res_outcome = OUT_FAULT;
            end else begin
                res_frame        = rd_frame;
                res_outcome      = OUT_EVICT;
                res_evict        = EVICT_W'(r_victim);
                tlb_upd.drop_en  = exec_go;
                pt_upd.evict_en  = exec_go;
            end
            tlb_upd.fill_en = exec_go;
            pt_upd.map_en   = exec_go;
        end
        tlb_upd.fill_page  = r_page;
        tlb_upd.fill_frame = res_frame;
        tlb_upd.drop_page  = r_victim;
        pt_upd.page        = r_page;
        pt_upd.frame       = res_frame;
        pt_upd.victim      = r_victim;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (exec_go) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_page    <= in_page;
            r_offset  <= i_s_tdata[OFFSET_BITS-1:0];
            r_victim  <= in_victim;
            r_present <= in_present;
        end
        if (exec_go) begin
            r_out_pa      <= PA_W'({res_frame, r_offset});
            r_out_outcome <= res_outcome;
            r_out_evict   <= res_evict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'({r_out_evict, r_out_outcome, r_out_pa});

endmodule

// ----- rtl/core/tlbpt_checker.sv -----
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tlbpt_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tvalid,
    input  logic                           o_s_tready,
    input  logic [tlbpt_pkg::M_DATA_W-1:0] o_m_tdata,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready
);
    import tlbpt_pkg::*;

    logic     s_beat;
    t_outcome m_outcome;

    assign s_beat    = i_s_tvalid && o_s_tready;
    assign m_outcome = t_outcome'(o_m_tdata[PA_W+OUTC_W-1:PA_W]);

    // a waiting result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before it was taken");

    // one request at a time: busy in the cycle after a request beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> !o_s_tready)
        else $error("request taken during translation");

    // a new result only appears at the end of a translation
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without a translation");

    // evicted page is zero unless the outcome is an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (m_outcome != OUT_EVICT)
            |-> (o_m_tdata[PA_W+OUTC_W+EVICT_W-1:PA_W+OUTC_W] == '0))
        else $error("evicted page set without eviction");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);
